[sv/m3i_pkg.sv]
// Shared constants, the cofactor index table and helper functions of the 3x3 matrix inverse.
package m3i_pkg;

    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int N_ELEM         = 9;
    localparam int THR_W          = 31;
    localparam int FRONT_STAGES   = 6;
    localparam int N_FLAGS        = 2;
    localparam int FLAG_SINGULAR  = 0;
    localparam int FLAG_SATURATED = 1;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    // Each cofactor is m[P]*m[Q] - m[R]*m[S], listed as P, Q, R, S.
    localparam int MINOR_IDX [N_ELEM][4] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int byte_round(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

[sv/matrix3_inverse_unit.sv]
// Top level of the pipelined 3x3 matrix inverse with nine divider lanes.
// Takes one 3x3 matrix per cycle while s_tready is high (the spare output entry is empty) and
// returns its inverse. The front pipeline forms the minors, the cofactors and the determinant
// in six register stages; nine divider lanes then run a restoring division with one quotient
// bit per stage, and a merge stage saturates the elements into a two-entry output buffer. A
// matrix whose determinant magnitude is zero or below the threshold written over cfg_data (in Q
// format) returns zeros with the singular flag set.
module matrix3_inverse_unit #(
    parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                                                         clk,
    input  logic                                                         rst_n,
    input  logic                                                         cfg_valid,
    output logic                                                         cfg_ready,
    input  logic [m3i_pkg::THR_W-1:0]                                    cfg_data,
    input  logic                                                         s_tvalid,
    output logic                                                         s_tready,
    // Fields from bit 0 up: m00, m01, m02, m10, m11, m12, m20, m21, m22, zero fill.
    input  logic [m3i_pkg::byte_round(m3i_pkg::N_ELEM*ELEM_WIDTH)-1:0]   s_tdata,
    output logic                                                         m_tvalid,
    input  logic                                                         m_tready,
    // Fields from bit 0 up: inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22,
    // zero fill.
    output logic [m3i_pkg::byte_round(m3i_pkg::N_ELEM*ELEM_WIDTH)-1:0]   m_tdata,
    // Fields from bit 0 up: singular, saturated.
    output logic [m3i_pkg::N_FLAGS-1:0]                                  m_tuser
);
    import m3i_pkg::*;

    localparam int W   = ELEM_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = 3 * W + 3;
    localparam int NW  = 2 * W + 1 + 2 * F;
    localparam int S   = FRONT_STAGES + W + 1;
    localparam int TDW = byte_round(N_ELEM * W);

    logic [THR_W-1:0]       thr_reg;
    logic [S-1:0]           v_reg;
    logic                   sing_reg [W+1];
    logic                   en;
    logic                   full;
    logic signed [W-1:0]    elem     [N_ELEM];
    logic [NW-1:0]          num_mag  [N_ELEM];
    logic                   num_neg  [N_ELEM];
    logic [DW-1:0]          adet;
    logic                   singular;
    logic [W-1:0]           quo      [N_ELEM];
    logic                   ovf      [N_ELEM];
    logic                   neg      [N_ELEM];
    logic [N_ELEM*W-1:0]    elems;

    assign cfg_ready = 1'b1;
    assign en        = !full;
    assign s_tready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[S-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg[0] <= singular;
            for (int s = 1; s <= W; s++)
            begin
                sing_reg[s] <= sing_reg[s-1];
            end
        end
    end

    for (genvar k = 0; k < N_ELEM; k++)
    begin : g_unpack
        assign elem[k] = s_tdata[k*W +: W];
    end

    m3i_front #(
        .ELEM_WIDTH (W),
        .FRAC_BITS  (F)
    ) u_front (
        .clk      (clk),
        .en       (en),
        .elem     (elem),
        .thr      (thr_reg),
        .num_mag  (num_mag),
        .num_neg  (num_neg),
        .adet     (adet),
        .singular (singular)
    );

    for (genvar k = 0; k < N_ELEM; k++)
    begin : g_lane
        m3i_div_lane #(
            .ELEM_WIDTH (W),
            .FRAC_BITS  (F)
        ) u_lane (
            .clk     (clk),
            .en      (en),
            .num     (num_mag[k]),
            .den     (adet),
            .neg     (num_neg[k]),
            .quo     (quo[k]),
            .ovf     (ovf[k]),
            .neg_out (neg[k])
        );
    end

    m3i_merge #(
        .ELEM_WIDTH (W)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (en && v_reg[S-1]),
        .quo      (quo),
        .ovf      (ovf),
        .neg      (neg),
        .singular (sing_reg[W]),
        .full     (full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .elems    (elems),
        .flags    (m_tuser)
    );

    assign m_tdata = TDW'(elems);

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[FLAG_SINGULAR] |-> (elems == '0) && !m_tuser[FLAG_SATURATED])
        else $error("singular item carries nonzero elements or saturation");

    a_full_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> m_tvalid)
        else $error("spare entry holds an item while the output register is empty");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted item did not enter the first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg) || $past(m_tvalid && m_tready))
        else $error("pipeline moved while stalled");

endmodule

[sv/m3i_front.sv]
// Front pipeline: minors, cofactors, determinant, singularity test and numerator preparation.
module m3i_front #(
    parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [ELEM_WIDTH-1:0]           elem [m3i_pkg::N_ELEM],
    input  logic [m3i_pkg::THR_W-1:0]              thr,
    output logic [2*ELEM_WIDTH+1+2*FRAC_BITS-1:0]  num_mag [m3i_pkg::N_ELEM],
    output logic                                   num_neg [m3i_pkg::N_ELEM],
    output logic [3*ELEM_WIDTH+3-1:0]              adet,
    output logic                                   singular
);
    import m3i_pkg::*;

    localparam int W  = ELEM_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int CW = 2 * W + 1;
    localparam int DW = 3 * W + 3;
    localparam int NW = CW + 2 * F;
    localparam int SW = imax(DW, THR_W + 2 * F);

    logic signed [W-1:0]  m0_reg  [N_ELEM];
    logic signed [PW-1:0] pa_reg  [N_ELEM];
    logic signed [PW-1:0] pb_reg  [N_ELEM];
    logic signed [W-1:0]  m1_reg  [3];
    logic signed [CW-1:0] a2_reg  [N_ELEM];
    logic signed [W-1:0]  m2_reg  [3];
    logic signed [CW-1:0] a3_reg  [N_ELEM];
    logic signed [PW:0]   plo_reg [3];
    logic signed [PW:0]   phi_reg [3];
    logic signed [CW-1:0] a4_reg  [N_ELEM];
    logic signed [DW-1:0] det_reg;
    logic signed [DW-1:0] det_next;
    logic [DW-1:0]        adet_next;
    logic [SW-1:0]        thr_sh;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                m0_reg[k] <= elem[k];
                pa_reg[k] <= PW'(m0_reg[MINOR_IDX[k][0]]) * PW'(m0_reg[MINOR_IDX[k][1]]);
                pb_reg[k] <= PW'(m0_reg[MINOR_IDX[k][2]]) * PW'(m0_reg[MINOR_IDX[k][3]]);
                a2_reg[k] <= CW'(pa_reg[k]) - CW'(pb_reg[k]);
                a3_reg[k] <= a2_reg[k];
                a4_reg[k] <= a3_reg[k];
            end
            for (int j = 0; j < 3; j++)
            begin
                m1_reg[j]  <= m0_reg[j];
                m2_reg[j]  <= m1_reg[j];
                plo_reg[j] <= (PW+1)'(m2_reg[j])
                              * (PW+1)'($signed({1'b0, a2_reg[3*j][W-1:0]}));
                phi_reg[j] <= (PW+1)'(m2_reg[j])
                              * (PW+1)'($signed(a2_reg[3*j][CW-1:W]));
            end
            det_reg  <= det_next;
            adet     <= adet_next;
            singular <= (adet_next == '0) || (SW'(adet_next) < thr_sh);
            for (int k = 0; k < N_ELEM; k++)
            begin
                num_mag[k] <= NW'(a4_reg[k][CW-1] ? (~a4_reg[k] + 1'b1) : a4_reg[k]) << (2 * F);
                num_neg[k] <= a4_reg[k][CW-1] ^ det_reg[DW-1];
            end
        end
    end

    always_comb
    begin
        det_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            det_next = det_next + (DW'(phi_reg[j]) <<< W) + DW'(plo_reg[j]);
        end
    end

    assign adet_next = det_reg[DW-1] ? (~det_reg + 1'b1) : det_reg;
    assign thr_sh    = SW'(thr) << (2 * F);

endmodule

[sv/m3i_div_lane.sv]
// One divider lane: pipelined restoring division of a cofactor magnitude by the determinant.
module m3i_div_lane #(
    parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic [2*ELEM_WIDTH+1+2*FRAC_BITS-1:0]  num,
    input  logic [3*ELEM_WIDTH+3-1:0]              den,
    input  logic                                   neg,
    output logic [ELEM_WIDTH-1:0]                  quo,
    output logic                                   ovf,
    output logic                                   neg_out
);
    import m3i_pkg::*;

    localparam int W  = ELEM_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int DW = 3 * W + 3;
    localparam int NW = 2 * W + 1 + 2 * F;
    localparam int XW = imax(NW, DW + W);

    logic [XW-1:0] rem_reg [W+1];
    logic [DW-1:0] den_reg [W+1];
    logic [W-1:0]  q_reg   [W+1];
    logic          ovf_reg [W+1];
    logic          neg_reg [W+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= XW'(num);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= XW'(num) >= (XW'(den) << W);
            neg_reg[0] <= neg;
        end
    end

    for (genvar s = 1; s <= W; s++)
    begin : g_step
        localparam int B = W - s;
        logic [XW:0]  trial;
        logic [W-1:0] q_next;

        assign trial = {1'b0, rem_reg[s-1]} - {1'b0, XW'(den_reg[s-1]) << B};

        always_comb
        begin
            q_next    = q_reg[s-1];
            q_next[B] = ~trial[XW];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= trial[XW] ? rem_reg[s-1] : trial[XW-1:0];
                den_reg[s] <= den_reg[s-1];
                q_reg[s]   <= q_next;
                ovf_reg[s] <= ovf_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
        end
    end

    assign quo     = q_reg[W];
    assign ovf     = ovf_reg[W];
    assign neg_out = neg_reg[W];

endmodule

[sv/m3i_merge.sv]
// Merge stage: saturates the lane quotients, gathers the flags and holds the output item.
module m3i_merge #(
    parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       push,
    input  logic [ELEM_WIDTH-1:0]                      quo [m3i_pkg::N_ELEM],
    input  logic                                       ovf [m3i_pkg::N_ELEM],
    input  logic                                       neg [m3i_pkg::N_ELEM],
    input  logic                                       singular,
    output logic                                       full,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [m3i_pkg::N_ELEM*ELEM_WIDTH-1:0]      elems,
    output logic [m3i_pkg::N_FLAGS-1:0]                flags
);
    import m3i_pkg::*;

    localparam int W  = ELEM_WIDTH;
    localparam int RW = N_ELEM * W + N_FLAGS;

    localparam logic [W-1:0] HALF = W'(1) << (W - 1);
    localparam logic [W-1:0] MAXP = HALF - 1'b1;

    logic [RW-1:0] res;
    logic [RW-1:0] out_reg;
    logic [RW-1:0] spare_reg;
    logic          out_valid_reg;
    logic          spare_valid_reg;
    logic          pop;

    always_comb
    begin
        logic [N_ELEM*W-1:0] e;
        logic                sat;
        e   = '0;
        sat = 1'b0;
        for (int k = 0; k < N_ELEM; k++)
        begin
            if (neg[k])
            begin
                if (ovf[k] || quo[k] > HALF)
                begin
                    e[k*W +: W] = HALF;
                    sat         = 1'b1;
                end
                else
                begin
                    e[k*W +: W] = ~quo[k] + 1'b1;
                end
            end
            else
            begin
                if (ovf[k] || quo[k][W-1])
                begin
                    e[k*W +: W] = MAXP;
                    sat         = 1'b1;
                end
                else
                begin
                    e[k*W +: W] = quo[k];
                end
            end
        end
        if (singular)
        begin
            e   = '0;
            sat = 1'b0;
        end
        res = {sat, singular, e};
    end

    assign pop = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (spare_valid_reg)
        begin
            if (pop)
            begin
                spare_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                spare_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (spare_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= spare_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                spare_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign full     = spare_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign elems    = out_reg[N_ELEM*W-1:0];
    assign flags    = out_reg[RW-1:N_ELEM*W];

endmodule

[verif/matrix3_inverse_unit_test.sv]
// Self-checking testbench of the streaming 3x3 matrix inverse: directed and random matrices.
`timescale 1ns / 100ps

module matrix3_inverse_unit_test;
    import m3i_pkg::*;

    localparam int EW = ELEM_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int DW = byte_round(N_ELEM * EW);
    localparam int LATENCY = 7 + EW;
    localparam int N_RANDOM = 1500;
    localparam int WIDE = 256;
    localparam logic [EW-1:0] MAXV = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] MINV = {1'b1, {(EW-1){1'b0}}};
    localparam logic [EW-1:0] ONE = EW'(1) << FB;

    typedef logic [EW-1:0] elem_t;
    typedef logic signed [WIDE-1:0] wide_t;

    typedef struct packed {
        logic              saturated;
        logic              singular;
        logic [DW-1:0]     elems;
    } inverse_t;

    typedef struct {
        logic [DW-1:0] elems;
        logic          has_known;
        inverse_t      known;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [THR_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DW-1:0] m_tdata;
    logic [N_FLAGS-1:0] m_tuser;

    logic [THR_W-1:0] threshold = THR_RESET;
    inverse_t expected_inverses[$];
    int mismatches = 0;
    int long_holdoff = 0;

    matrix3_inverse_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    function automatic wide_t widen(input elem_t e);
        return wide_t'(signed'(e));
    endfunction

    function automatic wide_t cofactor(input logic [DW-1:0] m, input int k);
        return widen(m[MINOR_IDX[k][0]*EW +: EW]) * widen(m[MINOR_IDX[k][1]*EW +: EW])
             - widen(m[MINOR_IDX[k][2]*EW +: EW]) * widen(m[MINOR_IDX[k][3]*EW +: EW]);
    endfunction

    function automatic inverse_t invert_matrix(input logic [DW-1:0] m,
                                               input logic [THR_W-1:0] thr);
        inverse_t r;
        wide_t adj[N_ELEM];
        wide_t det, adet, num, q, half;
        r = '0;
        for (int k = 0; k < N_ELEM; k++)
            adj[k] = cofactor(m, k);
        det = widen(m[0 +: EW]) * adj[0] + widen(m[EW +: EW]) * adj[3]
            + widen(m[2*EW +: EW]) * adj[6];
        adet = (det < 0) ? -det : det;
        if (adet == 0 || adet < (wide_t'(thr) <<< (2*FB))) begin
            r.singular = 1'b1;
            return r;
        end
        half = wide_t'(1) <<< (EW-1);
        for (int k = 0; k < N_ELEM; k++) begin
            num = adj[k] <<< (2*FB);
            // Signed division truncates toward zero, as required.
            q = num / det;
            if (q > half - 1) begin
                q = half - 1;
                r.saturated = 1'b1;
            end else if (q < -half) begin
                q = -half;
                r.saturated = 1'b1;
            end
            r.elems[k*EW +: EW] = q[EW-1:0];
        end
        return r;
    endfunction

    function automatic logic [DW-1:0] pack_matrix(input elem_t e[N_ELEM]);
        logic [DW-1:0] d;
        d = '0;
        for (int k = 0; k < N_ELEM; k++)
            d[k*EW +: EW] = e[k];
        return d;
    endfunction

    function automatic elem_t random_elem(input int kind);
        case (kind)
            0: return elem_t'($urandom);
            1: return elem_t'($urandom_range(0, 2*(1 << FB))) - ONE;
            2: return elem_t'(int'($urandom_range(0, 512)) - 256);
            default: return ($urandom_range(0, 1) != 0) ? MAXV : MINV;
        endcase
    endfunction

    function automatic logic [DW-1:0] random_matrix();
        elem_t e[N_ELEM];
        int kind;
        int shape;
        kind = $urandom_range(0, 9);
        shape = $urandom_range(0, 9);
        for (int k = 0; k < N_ELEM; k++) begin
            if (kind < 3) e[k] = random_elem(0);
            else if (kind < 8) e[k] = random_elem(1);
            else if (kind < 9) e[k] = random_elem(2);
            else e[k] = random_elem($urandom_range(0, 3));
        end
        if (shape == 0) begin
            for (int k = 0; k < 3; k++)
                e[6+k] = e[3+k];
        end else if (shape == 1) begin
            for (int k = 0; k < N_ELEM; k++)
                if (k % 4 != 0) e[k] = '0;
        end
        return pack_matrix(e);
    endfunction

    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        threshold = value;
    endtask

    task automatic send_matrix(input logic [DW-1:0] m, input bit has_known, input inverse_t known);
        inverse_t predicted;
        predicted = invert_matrix(m, threshold);
        if (has_known && predicted !== known) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Table entry disagrees with prediction: %h vs %h", known, predicted);
        end
        s_tvalid <= 1'b1;
        s_tdata <= m;
        do @(posedge clk); while (!s_tready);
        expected_inverses.push_back(predicted);
        if ($urandom_range(0, 2) == 0)
            random_gap();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_inverses.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    always @(posedge clk) begin
        inverse_t got;
        inverse_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got = {m_tuser[FLAG_SATURATED], m_tuser[FLAG_SINGULAR], m_tdata};
            if (expected_inverses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected inverse item: %h", got);
            end else begin
                want = expected_inverses.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Inverse mismatch: expected %h, got %h", want, got);
                end
            end
        end
    end

    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (long_holdoff > 0) begin
                m_tready <= 1'b0;
                long_holdoff--;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 2);
                repeat (n) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        stim_row_t table_rows[$];
        stim_row_t row;
        inverse_t sing;
        inverse_t ident;
        elem_t e[N_ELEM];
        logic [THR_W-1:0] thresholds[5];

        sing = '0;
        sing.singular = 1'b1;
        ident = '0;
        for (int k = 0; k < N_ELEM; k += 4) ident.elems[k*EW +: EW] = ONE;

        foreach (e[k]) e[k] = (k % 4 == 0) ? ONE : '0;
        row.elems = pack_matrix(e); row.has_known = 1; row.known = ident;
        table_rows.push_back(row);
        foreach (e[k]) e[k] = '0;
        row.elems = pack_matrix(e); row.known = sing;
        table_rows.push_back(row);
        foreach (e[k]) e[k] = ONE;
        row.elems = pack_matrix(e); row.known = sing;
        table_rows.push_back(row);
        foreach (e[k]) e[k] = (k % 4 == 0) ? elem_t'(1) : '0;
        row.elems = pack_matrix(e); row.known = sing;
        table_rows.push_back(row);
        row.has_known = 0;
        foreach (e[k]) e[k] = (k % 4 == 0) ? MAXV : '0;
        row.elems = pack_matrix(e); table_rows.push_back(row);
        foreach (e[k]) e[k] = (k % 4 == 0) ? MINV : '0;
        row.elems = pack_matrix(e); table_rows.push_back(row);
        foreach (e[k]) e[k] = (k % 4 == 0) ? elem_t'(2) : '0;
        row.elems = pack_matrix(e); table_rows.push_back(row);
        foreach (e[k]) e[k] = (k % 4 == 0) ? -ONE : '0;
        row.elems = pack_matrix(e); table_rows.push_back(row);
        foreach (e[k]) e[k] = (k % 2 == 0) ? MAXV : MINV;
        row.elems = pack_matrix(e); table_rows.push_back(row);
        foreach (e[k]) e[k] = (k == 2 || k == 4 || k == 6) ? MINV : elem_t'(k);
        row.elems = pack_matrix(e); table_rows.push_back(row);
        foreach (e[k]) e[k] = elem_t'(k * 3 + 1) << FB;
        e[8] = e[8] + ONE;
        row.elems = pack_matrix(e); table_rows.push_back(row);
        row.elems = {DW{1'b1}}; table_rows.push_back(row);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
            send_matrix(table_rows[i].elems, table_rows[i].has_known, table_rows[i].known);
        drain();

        thresholds = '{THR_W'(0), {THR_W{1'b1}}, THR_W'(1) << FB, THR_W'(1) << (FB - 4),
                       THR_W'(1)};
        foreach (thresholds[p]) begin
            write_threshold(thresholds[p]);
            if (p == 2) begin
                long_holdoff = 300;
                for (int i = 0; i < 100; i++)
                    send_matrix(random_matrix(), 1'b0, '0);
            end
            for (int i = 0; i < N_RANDOM / 5; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    foreach (e[k]) e[k] = random_elem(2);
                    send_matrix(pack_matrix(e), 1'b0, '0);
                end else begin
                    send_matrix(random_matrix(), 1'b0, '0);
                end
            end
            drain();
        end

        if (mismatches == 0 && expected_inverses.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
